>>> rtl/core/pdc_pkg.sv
package pdc_pkg;

    localparam int LETTER_W     = 5;
    localparam int ALPHA_SIZE   = 26;
    localparam int SQUARE_CELLS = 25;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [4:0]          t_pos;
    typedef logic [2:0]          t_coord;

    localparam t_letter LETTER_A = 5'd0;
    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_Z = 5'd25;
    localparam t_pos    CELLS_FULL = 5'd25;

    // request to the shared address unit
    typedef struct packed {
        t_pos pa;       // square position of first digraph letter
        t_pos pb;       // square position of second digraph letter
        logic decrypt;  // 1: shift back by one
        logic sel;      // 0: first result letter, 1: second
    } t_pair_req;

    function automatic t_coord pos_row(input t_pos p);
        t_coord r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_pos cell_addr(input t_coord row, input t_coord col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    function automatic t_coord pos_col(input t_pos p);
        t_pos base;
        base = cell_addr(pos_row(p), 3'd0);
        return 3'(p - base);
    endfunction

    // +1 mod 5 forward, +4 mod 5 (i.e. -1) backward
    function automatic t_coord step_mod5(input t_coord x, input logic back);
        t_coord r;
        if (back) begin
            r = (x == 3'd0) ? 3'd4 : 3'(x - 3'd1);
        end else begin
            r = (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/pdc_ram.sv
module pdc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pdc_addr_unit.sv
module pdc_addr_unit (
    input  pdc_pkg::t_pair_req i_req,
    output pdc_pkg::t_pos      o_addr
);

    pdc_pkg::t_coord ra, ca, rb, cb;
    pdc_pkg::t_coord my_row, my_col, other_col;

    always_comb begin
        ra = pdc_pkg::pos_row(i_req.pa);
        ca = pdc_pkg::pos_col(i_req.pa);
        rb = pdc_pkg::pos_row(i_req.pb);
        cb = pdc_pkg::pos_col(i_req.pb);

        my_row    = i_req.sel ? rb : ra;
        my_col    = i_req.sel ? cb : ca;
        other_col = i_req.sel ? ca : cb;

        if (ra == rb) begin
            // row rule, also covers an equal pair
            o_addr = pdc_pkg::cell_addr(my_row, pdc_pkg::step_mod5(my_col, i_req.decrypt));
        end else if (ca == cb) begin
            o_addr = pdc_pkg::cell_addr(pdc_pkg::step_mod5(my_row, i_req.decrypt), my_col);
        end else begin
            o_addr = pdc_pkg::cell_addr(my_row, other_col);
        end
    end

endmodule

>>> rtl/core/playfair_digraph_cipher.sv
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_stall      i_req_type, i_letter, i_last
// out       output     o_out_valid / i_out_stall    o_out_letter, o_out_last
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_cipher_mode
//
// A key letter is taken in the idle state; the last key letter adds an alphabet
// fill sweep, one letter per cycle through the square and place RAM ports.
// A text letter yields up to 3 pushed letters and up to 2 digraphs; each digraph
// reads both places from the place RAM, then for each result letter takes a
// square address from the shared address unit and reads the square RAM.
// Output stalls hold the sequencer in the result load steps; o_in_stall is high
// whenever the sequencer is not idle. Reset is synchronous, active low.
module playfair_digraph_cipher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [4:0]           i_letter,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [4:0]           o_out_letter,
    output logic                 o_out_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_cipher_mode
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_FILL = 9'b000000010,
        S_NEXT = 9'b000000100,
        S_RDA  = 9'b000001000,
        S_RDB  = 9'b000010000,
        S_ADR0 = 9'b000100000,
        S_OUT0 = 9'b001000000,
        S_ADR1 = 9'b010000000,
        S_OUT1 = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // config and key state
    logic                              r_cipher_mode;
    logic [pdc_pkg::ALPHA_SIZE-1:0]    r_used, n_used;
    pdc_pkg::t_pos                     r_fill_count, n_fill_count;
    logic                              r_square_ready, n_square_ready;
    pdc_pkg::t_letter                  r_key, n_key;

    // message formatting state
    pdc_pkg::t_letter r_held_letter, n_held_letter;
    logic             r_held_valid, n_held_valid;
    pdc_pkg::t_letter r_prev_letter, n_prev_letter;
    logic             r_prev_valid, n_prev_valid;

    // push list for the current text beat
    pdc_pkg::t_letter r_push0, n_push0;
    pdc_pkg::t_letter r_push1, n_push1;
    pdc_pkg::t_letter r_push2, n_push2;
    logic [1:0]       r_npush, n_npush;
    logic             r_last, n_last;

    // digraph in flight
    pdc_pkg::t_letter r_pair_b, n_pair_b;
    logic             r_pair_last, n_pair_last;
    pdc_pkg::t_pos    r_pa, n_pa;
    pdc_pkg::t_pos    r_pb, n_pb;

    // output register
    logic             r_out_valid, n_out_valid;
    pdc_pkg::t_letter r_out_letter, n_out_letter;
    logic             r_out_last, n_out_last;

    // RAM ports
    logic             sq_we, sq_re;
    pdc_pkg::t_pos    sq_waddr, sq_raddr;
    pdc_pkg::t_letter sq_wdata, sq_rdata;
    logic             pl_we, pl_re;
    pdc_pkg::t_letter pl_waddr, pl_raddr;
    pdc_pkg::t_pos    pl_wdata, pl_rdata;

    pdc_pkg::t_pair_req pair_req;

    logic             in_accept;
    logic             out_free;
    logic             letter_ok;
    pdc_pkg::t_letter letter_fold;
    logic             ins_x;
    logic             pad_x;
    logic [1:0]       list_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_letter = r_out_letter;
    assign o_out_last   = r_out_last;

    assign letter_ok   = (i_letter <= pdc_pkg::LETTER_Z);
    assign letter_fold = (i_letter == pdc_pkg::LETTER_J) ? pdc_pkg::LETTER_I : i_letter;

    // formatting decisions for a text beat, taken against the state at accept
    assign ins_x    = !r_cipher_mode && r_prev_valid && (r_prev_letter == letter_fold)
                      && letter_ok;
    assign list_cnt = ins_x ? 2'd2 : (letter_ok ? 2'd1 : 2'd0);
    assign pad_x    = i_last && (r_held_valid ^ list_cnt[0]) && !r_cipher_mode;

    // shared address unit: one square address per result letter
    assign pair_req.pa      = r_pa;
    assign pair_req.pb      = r_pb;
    assign pair_req.decrypt = r_cipher_mode;
    assign pair_req.sel     = (r_state == S_ADR1);

    pdc_addr_unit u_addr (
        .i_req  (pair_req),
        .o_addr (sq_raddr)
    );

    pdc_ram #(
        .WIDTH (pdc_pkg::LETTER_W),
        .DEPTH (pdc_pkg::SQUARE_CELLS)
    ) u_square (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_waddr),
        .i_wdata (sq_wdata),
        .i_re    (sq_re),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    pdc_ram #(
        .WIDTH (pdc_pkg::LETTER_W),
        .DEPTH (pdc_pkg::ALPHA_SIZE)
    ) u_place (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_fill_count   = r_fill_count;
        n_square_ready = r_square_ready;
        n_key          = r_key;
        n_held_letter  = r_held_letter;
        n_held_valid   = r_held_valid;
        n_prev_letter  = r_prev_letter;
        n_prev_valid   = r_prev_valid;
        n_push0        = r_push0;
        n_push1        = r_push1;
        n_push2        = r_push2;
        n_npush        = r_npush;
        n_last         = r_last;
        n_pair_b       = r_pair_b;
        n_pair_last    = r_pair_last;
        n_pa           = r_pa;
        n_pb           = r_pb;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_letter   = r_out_letter;
        n_out_last     = r_out_last;

        sq_we    = 1'b0;
        sq_waddr = r_fill_count;
        sq_wdata = letter_fold;
        sq_re    = 1'b0;
        pl_we    = 1'b0;
        pl_waddr = letter_fold;
        pl_wdata = r_fill_count;
        pl_re    = 1'b0;
        pl_raddr = r_pair_b;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && !i_req_type) begin
                    // key beat; a key after a ready square starts over
                    if (r_square_ready) begin
                        n_used         = '0;
                        n_fill_count   = '0;
                        n_square_ready = 1'b0;
                        n_held_letter  = '0;
                        n_held_valid   = 1'b0;
                        n_prev_letter  = '0;
                        n_prev_valid   = 1'b0;
                    end
                    if (letter_ok && !n_used[letter_fold] &&
                        (n_fill_count < pdc_pkg::CELLS_FULL)) begin
                        sq_we    = 1'b1;
                        sq_waddr = n_fill_count;
                        sq_wdata = letter_fold;
                        pl_we    = 1'b1;
                        pl_waddr = letter_fold;
                        pl_wdata = n_fill_count;
                        n_used[letter_fold] = 1'b1;
                        n_fill_count = 5'(n_fill_count + 5'd1);
                    end
                    if (i_last) begin
                        n_key   = pdc_pkg::LETTER_A;
                        n_state = S_FILL;
                    end
                end else if (in_accept && r_square_ready) begin
                    // text beat: unused slots default to x, so padding is a count bump
                    n_push0 = ins_x ? pdc_pkg::LETTER_X
                                    : (letter_ok ? letter_fold : pdc_pkg::LETTER_X);
                    n_push1 = ins_x ? letter_fold : pdc_pkg::LETTER_X;
                    n_push2 = pdc_pkg::LETTER_X;
                    n_npush = 2'(list_cnt + {1'b0, pad_x});
                    n_last  = i_last;
                    if (letter_ok) begin
                        n_prev_letter = letter_fold;
                        n_prev_valid  = 1'b1;
                    end
                    n_state = S_NEXT;
                end
            end
            S_FILL: begin
                if ((r_key != pdc_pkg::LETTER_J) && !r_used[r_key] &&
                    (r_fill_count < pdc_pkg::CELLS_FULL)) begin
                    sq_we    = 1'b1;
                    sq_waddr = r_fill_count;
                    sq_wdata = r_key;
                    pl_we    = 1'b1;
                    pl_waddr = r_key;
                    pl_wdata = r_fill_count;
                    n_used[r_key] = 1'b1;
                    n_fill_count  = 5'(r_fill_count + 5'd1);
                end
                if (r_key == pdc_pkg::LETTER_Z) begin
                    n_square_ready = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_key = 5'(r_key + 5'd1);
                end
            end
            S_NEXT: begin
                if (r_npush == 2'd0) begin
                    if (r_last) begin
                        n_held_letter = '0;
                        n_held_valid  = 1'b0;
                        n_prev_letter = '0;
                        n_prev_valid  = 1'b0;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_push0 = r_push1;
                    n_push1 = r_push2;
                    n_npush = 2'(r_npush - 2'd1);
                    if (r_held_valid) begin
                        // digraph complete; last pair when fewer than two pushes remain
                        n_pair_b     = r_push0;
                        n_held_valid = 1'b0;
                        n_pair_last  = r_last && (r_npush != 2'd3);
                        pl_re        = 1'b1;
                        pl_raddr     = r_held_letter;
                        n_state      = S_RDA;
                    end else begin
                        n_held_letter = r_push0;
                        n_held_valid  = 1'b1;
                    end
                end
            end
            S_RDA: begin
                n_pa     = pl_rdata;
                pl_re    = 1'b1;
                pl_raddr = r_pair_b;
                n_state  = S_RDB;
            end
            S_RDB: begin
                n_pb    = pl_rdata;
                n_state = S_ADR0;
            end
            S_ADR0: begin
                sq_re   = 1'b1;
                n_state = S_OUT0;
            end
            S_OUT0: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = sq_rdata;
                    n_out_last   = 1'b0;
                    n_state      = S_ADR1;
                end
            end
            S_ADR1: begin
                sq_re   = 1'b1;
                n_state = S_OUT1;
            end
            S_OUT1: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = sq_rdata;
                    n_out_last   = r_pair_last;
                    n_state      = S_NEXT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cipher_mode  <= 1'b0;
            r_used         <= '0;
            r_fill_count   <= '0;
            r_square_ready <= 1'b0;
            r_key          <= '0;
            r_held_letter  <= '0;
            r_held_valid   <= 1'b0;
            r_prev_letter  <= '0;
            r_prev_valid   <= 1'b0;
            r_npush        <= '0;
            r_last         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cipher_mode <= i_cfg_cipher_mode;
            end
            r_used         <= n_used;
            r_fill_count   <= n_fill_count;
            r_square_ready <= n_square_ready;
            r_key          <= n_key;
            r_held_letter  <= n_held_letter;
            r_held_valid   <= n_held_valid;
            r_prev_letter  <= n_prev_letter;
            r_prev_valid   <= n_prev_valid;
            r_npush        <= n_npush;
            r_last         <= n_last;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_push0      <= n_push0;
        r_push1      <= n_push1;
        r_push2      <= n_push2;
        r_pair_b     <= n_pair_b;
        r_pair_last  <= n_pair_last;
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
    end

    // a ready square is always completely filled
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_square_ready |-> (r_fill_count == pdc_pkg::CELLS_FULL))
        else $error("square ready with unfilled cells");

    // fill count never runs past the square
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= pdc_pkg::CELLS_FULL)
        else $error("fill count beyond square size");

    // message end clears held and previous letters
    a_msg_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT && r_npush == 2'd0 && r_last)
        |=> (!r_held_valid && !r_prev_valid && r_state == S_IDLE))
        else $error("message end left formatting state");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && (r_state == S_OUT0 || r_state == S_OUT1))
        |=> (r_state == $past(r_state)))
        else $error("result step advanced over a stalled beat");

endmodule
